// File: sv/igsg_pkg.sv
// Package for the inverse Gaussian sampler: stage numbering and the record
// types that travel down its pipeline. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package igsg_pkg;

    // Square root: 32 result bits, two bits retired per stage.
    localparam int SQ_STEPS  = 32;
    localparam int SQ_PER    = 2;
    localparam int SQ_STAGES = SQ_STEPS / SQ_PER;

    // Division: 32 quotient bits, two bits retired per stage.
    localparam int DV_STEPS  = 32;
    localparam int DV_PER    = 2;
    localparam int DV_STAGES = DV_STEPS / DV_PER;

    // Stage numbering along the pipeline.
    localparam int ST_IN   = 0;
    localparam int ST_SQR  = 1;
    localparam int ST_MY   = 2;
    localparam int ST_SUM  = 3;
    localparam int ST_NA   = 4;
    localparam int ST_NB   = 5;
    localparam int ST_SQ0  = 6;
    localparam int ST_XF   = ST_SQ0 + SQ_STAGES;
    localparam int ST_CMP  = ST_XF + 1;
    localparam int ST_PP   = ST_XF + 2;
    localparam int ST_PR   = ST_XF + 3;
    localparam int ST_DI   = ST_XF + 4;
    localparam int ST_DV0  = ST_DI + 1;
    localparam int ST_OUT  = ST_DV0 + DV_STAGES;
    localparam int ST_NUM  = ST_OUT + 1;

    localparam logic [31:0] SAMPLE_MAX = 32'hFFFF_FFFF;

    // Side information that follows each request down the pipeline.
    typedef struct packed {
        logic [31:0] m;
        logic [31:0] l;
        logic [15:0] u;
        logic [61:0] ay;
        logic        bad;
        logic        fb;
    } t_side;

    typedef struct packed {
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] s;
    } t_norm;

    typedef struct packed {
        logic [63:0] v;
        logic [63:0] r;
    } t_sq;

    typedef struct packed {
        logic [63:0] rem;
        logic [31:0] lo;
        logic [31:0] q;
        logic [62:0] den;
        logic        big;
    } t_dv;

endpackage

`default_nettype wire

// File: sv/inverse_gaussian_sample_guarded.sv
// Inverse Gaussian sampler, Michael-Schucany-Haas method, fully pipelined.
// Depends on igsg_pkg for stage numbering and record types.
`timescale 1ns / 1ps
`default_nettype none

// One request enters every cycle while the output side keeps taking results. The
// depth is set by the two 32-step square roots (two steps per stage) and the
// 32-step restoring division (two quotient bits per stage). Every stage holds
// its own valid bit, so a stalled output only stops the stages that are full.
module inverse_gaussian_sample_guarded
    import igsg_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // mean_value[31:0], shape_value[63:32], normal_draw[79:64], uniform_draw[95:80]
    input  wire logic [95:0] i_s_axis_tdata,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // sample_out[31:0]
    output logic [31:0]      o_m_axis_tdata,
    // bad_input[0], used_fallback[1], saturated[2]
    output logic [2:0]       o_m_axis_tuser
);

    // One normalising step: shift a, b and their sum by 2t while the sum stays below 2^62.
    function automatic t_norm norm_step(t_norm x, int t);
        t_norm y;
        y = x;
        if ((x.s >> (62 - 2 * t)) == 64'd0) begin
            y.a = x.a << (2 * t);
            y.b = x.b << (2 * t);
            y.s = x.s << (2 * t);
        end
        return y;
    endfunction

    // One digit step of the integer square root.
    function automatic t_sq sq_step(t_sq x, int i);
        logic [63:0] bit_v;
        logic [63:0] trial;
        t_sq         y;
        bit_v = 64'd1 << (62 - 2 * i);
        trial = x.r + bit_v;
        if (x.v >= trial) begin
            y.v = x.v - trial;
            y.r = (x.r >> 1) + bit_v;
        end else begin
            y.v = x.v;
            y.r = x.r >> 1;
        end
        return y;
    endfunction

    // One restoring division step.
    function automatic t_dv dv_step(t_dv x);
        logic [63:0] t;
        logic        qb;
        t_dv         y;
        y  = x;
        t  = {x.rem[62:0], x.lo[31]};
        qb = 1'b0;
        if (t >= {1'b0, x.den}) begin
            t  = t - {1'b0, x.den};
            qb = 1'b1;
        end
        y.rem = t;
        y.lo  = {x.lo[30:0], 1'b0};
        y.q   = {x.q[30:0], qb};
        return y;
    endfunction

    logic [ST_NUM-1:0] r_vld;
    logic [ST_NUM:0]   en;
    t_side             r_side [ST_NUM];
    t_side             n_side [ST_NUM];

    logic [15:0]  r_z;
    logic [30:0]  r_y;
    logic [15:0]  n_mag;
    t_norm        r_n0, r_n1, r_n2;
    t_norm        n_n1, n_n2;
    t_sq          r_p [SQ_STAGES];
    t_sq          r_q [SQ_STAGES];
    t_sq          n_p [SQ_STAGES];
    t_sq          n_q [SQ_STAGES];
    logic [31:0]  n_pr, n_qr;
    logic         n_fb;
    logic [62:0]  r_xn, r_xd, r_xs;
    logic [78:0]  n_lhs;
    logic         n_small;
    logic [62:0]  r_num, r_den_c, r_den_p, r_den_r;
    logic [63:0]  r_pp0;
    logic [62:0]  r_pp1;
    logic [94:0]  r_prod;
    t_dv          r_dv [DV_STAGES + 1];
    t_dv          n_dv [DV_STAGES + 1];
    logic [31:0]  r_out_data;
    logic [2:0]   r_out_user;

    // Each stage moves when it is empty or the stage after it moves.
    always_comb begin
        en[ST_NUM] = i_m_axis_tready;
        for (int k = ST_NUM - 1; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k + 1];
        end
    end

    assign o_s_axis_tready = en[0];
    assign o_m_axis_tvalid = r_vld[ST_OUT];
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_s_axis_tvalid;
            end
            for (int k = 1; k < ST_NUM; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k - 1];
                end
            end
        end
    end

    // Side record: filled at the input, updated where the product and fallback are known.
    always_comb begin
        n_side[0].m   = i_s_axis_tdata[31:0];
        n_side[0].l   = i_s_axis_tdata[63:32];
        n_side[0].u   = i_s_axis_tdata[95:80];
        n_side[0].ay  = '0;
        n_side[0].bad = (i_s_axis_tdata[31:0] == 32'd0) || (i_s_axis_tdata[63:32] == 32'd0);
        n_side[0].fb  = 1'b0;
        for (int k = 1; k < ST_NUM; k++) begin
            n_side[k] = r_side[k - 1];
        end
        n_side[ST_MY].ay = 62'(r_side[ST_MY - 1].m * r_y);
        n_side[ST_XF].fb = n_fb;
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < ST_NUM; k++) begin
            if (en[k]) begin
                r_side[k] <= n_side[k];
            end
        end
    end

    // Front end: square the normal draw, form A = M*Y and B = L*2^26, normalise.
    assign n_mag = r_z[15] ? (16'd0 - r_z) : r_z;

    always_comb begin
        n_n1 = norm_step(r_n0, 16);
        n_n1 = norm_step(n_n1, 8);
        n_n2 = norm_step(r_n1, 4);
        n_n2 = norm_step(n_n2, 2);
        n_n2 = norm_step(n_n2, 1);
    end

    always_ff @(posedge i_clk) begin
        if (en[ST_IN]) begin
            r_z <= i_s_axis_tdata[79:64];
        end
        if (en[ST_SQR]) begin
            r_y <= 31'(n_mag * n_mag);
        end
        if (en[ST_SUM]) begin
            r_n0.a <= {2'b00, r_side[ST_SUM - 1].ay};
            r_n0.b <= {6'd0, r_side[ST_SUM - 1].l, 26'd0};
            r_n0.s <= {2'b00, r_side[ST_SUM - 1].ay} + {6'd0, r_side[ST_SUM - 1].l, 26'd0};
        end
        if (en[ST_NA]) begin
            r_n1 <= n_n1;
        end
        if (en[ST_NB]) begin
            r_n2 <= n_n2;
        end
    end

    // Two square roots side by side: P of A+B and Q of A.
    always_comb begin
        for (int j = 0; j < SQ_STAGES; j++) begin
            if (j == 0) begin
                n_p[j] = '{v: r_n2.s, r: 64'd0};
                n_q[j] = '{v: r_n2.a, r: 64'd0};
            end else begin
                n_p[j] = r_p[j - 1];
                n_q[j] = r_q[j - 1];
            end
            for (int i = 0; i < SQ_PER; i++) begin
                n_p[j] = sq_step(n_p[j], j * SQ_PER + i);
                n_q[j] = sq_step(n_q[j], j * SQ_PER + i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < SQ_STAGES; j++) begin
            if (en[ST_SQ0 + j]) begin
                r_p[j] <= n_p[j];
                r_q[j] <= n_q[j];
            end
        end
    end

    // x = (P-Q)/(P+Q), or L*2^24 / (M*Y) when the roots agree.
    assign n_pr  = r_p[SQ_STAGES - 1].r[31:0];
    assign n_qr  = r_q[SQ_STAGES - 1].r[31:0];
    assign n_fb  = (n_pr == n_qr);

    // Acceptance test u*(xd+xn) < xd, then the operands of the final division.
    assign n_lhs   = 79'(r_side[ST_CMP - 1].u * r_xs);
    assign n_small = n_lhs < {r_xd, 16'd0};

    always_ff @(posedge i_clk) begin
        if (en[ST_XF]) begin
            if (n_fb) begin
                r_xn <= {7'd0, r_side[ST_XF - 1].l, 24'd0};
                r_xd <= {1'b0, r_side[ST_XF - 1].ay};
                r_xs <= {7'd0, r_side[ST_XF - 1].l, 24'd0} + {1'b0, r_side[ST_XF - 1].ay};
            end else begin
                r_xn <= {31'd0, n_pr - n_qr};
                r_xd <= {30'd0, {1'b0, n_pr} + {1'b0, n_qr}};
                r_xs <= {30'd0, n_pr, 1'b0};
            end
        end
        if (en[ST_CMP]) begin
            r_num   <= n_small ? r_xn : r_xd;
            r_den_c <= n_small ? r_xd : r_xn;
        end
        if (en[ST_PP]) begin
            r_pp0   <= r_side[ST_PP - 1].m * r_num[31:0];
            r_pp1   <= r_side[ST_PP - 1].m * r_num[62:32];
            r_den_p <= r_den_c;
        end
        if (en[ST_PR]) begin
            r_prod  <= {31'd0, r_pp0} + {r_pp1, 32'd0};
            r_den_r <= r_den_p;
        end
    end

    // Restoring division of M*num by den; a quotient of 2^32 or more saturates.
    always_comb begin
        n_dv[0].rem = {1'b0, r_prod[94:32]};
        n_dv[0].lo  = r_prod[31:0];
        n_dv[0].q   = 32'd0;
        n_dv[0].den = r_den_r;
        n_dv[0].big = (r_prod[94:32] >= r_den_r);
        for (int j = 1; j <= DV_STAGES; j++) begin
            n_dv[j] = r_dv[j - 1];
            for (int i = 0; i < DV_PER; i++) begin
                n_dv[j] = dv_step(n_dv[j]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j <= DV_STAGES; j++) begin
            if (en[ST_DI + j]) begin
                r_dv[j] <= n_dv[j];
            end
        end
    end

    // Output register: bad input forces zero, otherwise saturate on overflow.
    always_ff @(posedge i_clk) begin
        if (en[ST_OUT]) begin
            if (r_side[ST_OUT - 1].bad) begin
                r_out_data <= 32'd0;
                r_out_user <= 3'b001;
            end else begin
                r_out_data <= r_dv[DV_STAGES].big ? SAMPLE_MAX : r_dv[DV_STAGES].q;
                r_out_user <= {r_dv[DV_STAGES].big, r_side[ST_OUT - 1].fb, 1'b0};
            end
        end
    end

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
// Self-checking bench for the inverse Gaussian sampler: a directed set of requests and
// random requests under several idling phases, each result checked against a predictor.
// Depends on igsg_pkg and inverse_gaussian_sample_guarded.
`timescale 1ns / 1ps

module tb_top;
    import igsg_pkg::*;

    typedef struct packed {
        logic [31:0] sample;
        logic        bad;
        logic        fb;
        logic        sat;
    } t_draw;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [95:0] i_s_axis_tdata;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [31:0] o_m_axis_tdata;
    logic [2:0]  o_m_axis_tuser;

    logic [95:0] pending_reqs[$];
    t_draw       expected_draws[$];
    int          send_idle_pct;
    int          recv_stall_pct;
    int          mismatches;
    int          cycle_count;

    inverse_gaussian_sample_guarded dut (.*);

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // floor(a*b/c), clipped to 32 bits; over is set when clipped.
    function automatic logic [31:0] scaled_ratio(input logic [63:0] a, input logic [63:0] b,
                                                 input logic [63:0] c, output logic over);
        logic [127:0] q;
        if (c == 0) begin
            over = 1'b1;
            return 32'hFFFF_FFFF;
        end
        q = ({64'd0, a} * {64'd0, b}) / {64'd0, c};
        over = (q >> 32) != 0;
        return over ? 32'hFFFF_FFFF : q[31:0];
    endfunction

    function automatic logic [63:0] root_floor(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= r + bitv) begin
                v -= r + bitv;
                r = (r >> 1) + bitv;
            end else begin
                r >>= 1;
            end
            bitv >>= 2;
        end
        return r;
    endfunction

    // Predicts one sample from a packed request.
    function automatic t_draw predict_draw(input logic [95:0] req);
        logic [63:0]  m, l, mag, y, a, b, p, q, xn, xd;
        logic [15:0]  z, u;
        logic [127:0] lhs, rhs;
        logic         over;
        t_draw        d;
        m = {32'd0, req[31:0]};
        l = {32'd0, req[63:32]};
        z = req[79:64];
        u = req[95:80];
        d = '0;
        if (m == 0 || l == 0) begin
            d.bad = 1'b1;
            return d;
        end
        mag = z[15] ? 64'h10000 - z : z;
        y = mag * mag;
        a = m * y;
        b = l << 26;
        while (((a + b) >> 60) == 0) begin
            a <<= 2;
            b <<= 2;
        end
        p = root_floor(a + b);
        q = root_floor(a);
        if (p == q) begin
            d.fb = 1'b1;
            xn = l << 24;
            xd = m * y;
        end else begin
            xn = p - q;
            xd = p + q;
        end
        lhs = {112'd0, u} * {64'd0, xd + xn};
        rhs = {64'd0, xd} << 16;
        if (lhs < rhs) d.sample = scaled_ratio(m, xn, xd, over);
        else d.sample = scaled_ratio(m, xd, xn, over);
        d.sat = over;
        return d;
    endfunction

    function automatic logic [95:0] make_req(input logic [31:0] m, input logic [31:0] l,
                                             input logic [15:0] z, input logic [15:0] u);
        return {u, z, l, m};
    endfunction

    // Mostly sensible means and shapes, with edge values now and then.
    function automatic logic [31:0] rand_param();
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 3);
            1: return $urandom;
            2: return 32'hFFFF_FFFF - $urandom_range(0, 3);
            default: return $urandom_range(32'h0000_1000, 32'h0010_0000);
        endcase
    endfunction

    // Driver: presents queued requests, idling at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata  <= '0;
        end else if (!i_s_axis_tvalid || o_s_axis_tready) begin
            if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                i_s_axis_tdata  <= pending_reqs[0];
                i_s_axis_tvalid <= 1'b1;
                expected_draws.push_back(predict_draw(pending_reqs.pop_front()));
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result side: random stalls and comparison against the oldest expectation.
    always @(posedge i_clk) begin
        t_draw want;
        t_draw got;
        cycle_count <= cycle_count + 1;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= $urandom_range(0, 99) >= recv_stall_pct;
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got = {o_m_axis_tdata, o_m_axis_tuser[0], o_m_axis_tuser[1], o_m_axis_tuser[2]};
                if (expected_draws.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10) $display("Unexpected result %p", got);
                end else begin
                    want = expected_draws.pop_front();
                    if (got !== want) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("Mismatch: expected %p, got %p", want, got);
                    end
                end
            end
        end
    end

    // Timeout guard.
    always @(posedge i_clk) begin
        if (cycle_count > 400000) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || i_s_axis_tvalid || expected_draws.size() != 0)
            @(posedge i_clk);
    endtask

    // Stimulus and end of run.
    initial begin
        logic [15:0] zs[6];
        send_idle_pct = 0;
        recv_stall_pct = 0;
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: zero mean or shape, zero draw, field extremes, saturation.
        zs = '{16'h0000, 16'h8000, 16'h7FFF, 16'h1000, 16'hF000, 16'h0001};
        pending_reqs.push_back(make_req(0, 32'h10000, 16'h1000, 16'h8000));
        pending_reqs.push_back(make_req(32'h10000, 0, 16'h1000, 16'h8000));
        pending_reqs.push_back(make_req(0, 0, 16'hFFFF, 16'hFFFF));
        foreach (zs[i]) begin
            pending_reqs.push_back(make_req(32'h10000, 32'h10000, zs[i], 16'h0000));
            pending_reqs.push_back(make_req(32'hFFFF_FFFF, 32'h1, zs[i], 16'hFFFF));
            pending_reqs.push_back(make_req(32'h1, 32'hFFFF_FFFF, zs[i], 16'h8000));
        end

        // Random phases: none, sender idle, receiver stall, both.
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1) ? 74 : (ph == 3) ? 38 : 0;
            recv_stall_pct = (ph == 2) ? 74 : (ph == 3) ? 38 : 0;
            repeat (100)
                pending_reqs.push_back(make_req(rand_param(), rand_param(),
                                                $urandom, $urandom));
            wait_drained();
        end
        repeat (100) @(posedge i_clk);

        if (mismatches == 0 && expected_draws.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

// File: filelist.f
sv/igsg_pkg.sv
sv/inverse_gaussian_sample_guarded.sv
tb/sv/tb_top.sv
